@@ src/ist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Types and constants shared by the identity substitution table and its cells.
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_UNIFY  = 1'b1;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED  = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_ZERO_KEY = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [31:0] key_id;
      logic [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [31:0] mapped_id;
      logic        found;
      logic [1:0]  status;
   } rsp_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic compare_en;
      logic tgt_en;
      logic find_en;
      logic update_en;
      logic write_hit;
      logic write_new;
      logic rewrite_en;
      logic b_en;
   } cell_ctrl_type;

   // match flags reported by one cell
   typedef struct packed {
      logic khit;
      logic thit;
      logic whit;
   } cell_hit_type;

endpackage

@@ src/identity_substitution_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_substitution_table
// Bounded key-to-value identity table with lookup and transitive unify.
// ----------------------------------------------------------------------------
// sequence: an accepted request passes the S_CMP, S_RESOLVE, S_FIND and S_UPDATE states,
//   compare, resolve, find and update passes over the row of entry cells; the result is
//   registered from S_UPDATE, and busy stays high and no new request is taken until S_IDLE
// reset: synchronous, clears all valid bits and the sequencer
// the receiver cannot stall; each result is shown for one cycle on rsp_valid
module identity_substitution_table
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_CMP     = 5'b00010,
      S_RESOLVE = 5'b00100,
      S_FIND    = 5'b01000,
      S_UPDATE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic               mode_ff;
   logic [ID_BITS-1:0] key_ff, tgt_ff;
   logic [ID_BITS-1:0] mapped_ff, wkey_ff, wval_ff, ra_ff, rb_ff, rv_ff;
   logic               found_ff, do_write_ff, rewrite_ff, b_en_ff;
   logic [1:0]         status_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   cell_ctrl_type      ctrl;
   logic               valid_vec [TABLE_DEPTH];
   cell_hit_type       hit_vec   [TABLE_DEPTH];
   logic [ID_BITS-1:0] kval_vec  [TABLE_DEPTH];
   logic [ID_BITS-1:0] tval_vec  [TABLE_DEPTH];

   logic               ks_found, ts_found, found_w;
   logic [ID_BITS-1:0] existing, tval, res;
   logic [ID_BITS-1:0] mapped_c, wkey_c, wval_c, ra_c, rb_c, rv_c;
   logic               do_write_c, rewrite_c, b_en_c;
   logic [1:0]         status_c;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         logic prev_v;
         if (gi == 0) begin : g_head
            assign prev_v = 1'b1;
         end else begin : g_body
            assign prev_v = valid_vec[gi-1];
         end
         ist_cell #(.ID_BITS(ID_BITS)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .cmp_key     (key_ff),
            .cmp_tgt     (tgt_ff),
            .find_key    (wkey_ff),
            .write_value (wval_ff),
            .rw_a        (ra_ff),
            .rw_b        (rb_ff),
            .rw_v        (rv_ff),
            .prev_valid  (prev_v),
            .valid       (valid_vec[gi]),
            .hit         (hit_vec[gi]),
            .khit_value  (kval_vec[gi]),
            .thit_value  (tval_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      ks_found = 1'b0;
      ts_found = 1'b0;
      found_w  = 1'b0;
      existing = '0;
      tval     = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         ks_found = ks_found | hit_vec[i].khit;
         ts_found = ts_found | hit_vec[i].thit;
         found_w  = found_w  | hit_vec[i].whit;
         existing = existing | kval_vec[i];
         tval     = tval     | tval_vec[i];
      end
   end

   always_comb begin
      ctrl.compare_en = (state_ff == S_CMP);
      ctrl.tgt_en     = (tgt_ff != '0);
      ctrl.find_en    = (state_ff == S_FIND);
      ctrl.update_en  = (state_ff == S_UPDATE);
      ctrl.write_hit  = do_write_ff && found_w;
      ctrl.write_new  = do_write_ff && !found_w;
      ctrl.rewrite_en = rewrite_ff;
      ctrl.b_en       = b_en_ff;
   end

   // lookup result and unify decision
   always_comb begin
      res        = (tgt_ff == '0) ? '0 : (ts_found ? tval : tgt_ff);
      mapped_c   = res;
      wkey_c     = key_ff;
      wval_c     = res;
      ra_c       = key_ff;
      rb_c       = key_ff;
      rv_c       = res;
      do_write_c = 1'b0;
      rewrite_c  = 1'b0;
      b_en_c     = 1'b0;
      status_c   = STATUS_DONE;
      if (mode_ff == MODE_LOOKUP) begin
         mapped_c = ks_found ? existing : key_ff;
      end else if (key_ff == '0) begin
         status_c = STATUS_ZERO_KEY;
      end else if (key_ff == tgt_ff) begin
         status_c = STATUS_SKIPPED;
      end else if (!ks_found) begin
         do_write_c = 1'b1;
         rewrite_c  = 1'b1;
      end else if (existing == '0) begin
         if (res != '0) begin
            wkey_c     = res;
            wval_c     = '0;
            ra_c       = res;
            rv_c       = '0;
            do_write_c = 1'b1;
            rewrite_c  = 1'b1;
         end else begin
            status_c = STATUS_SKIPPED;
         end
      end else if (res == '0) begin
         wkey_c     = existing;
         wval_c     = '0;
         ra_c       = existing;
         rb_c       = key_ff;
         rv_c       = '0;
         do_write_c = 1'b1;
         rewrite_c  = 1'b1;
         b_en_c     = 1'b1;
      end else begin
         wkey_c     = tgt_ff;
         wval_c     = existing;
         ra_c       = res;
         rv_c       = existing;
         do_write_c = 1'b1;
         rewrite_c  = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (start) state_in = S_CMP;
         S_CMP:     state_in = S_RESOLVE;
         S_RESOLVE: state_in = S_FIND;
         S_FIND:    state_in = S_UPDATE;
         S_UPDATE:  state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         do_write_ff  <= 1'b0;
         rewrite_ff   <= 1'b0;
         b_en_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_UPDATE);
         if (state_ff == S_RESOLVE) begin
            do_write_ff <= do_write_c;
            rewrite_ff  <= rewrite_c;
            b_en_ff     <= b_en_c;
         end else if (state_ff == S_UPDATE) begin
            do_write_ff <= 1'b0;
            rewrite_ff  <= 1'b0;
            b_en_ff     <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         mode_ff <= req_data.mode;
         key_ff  <= ID_BITS'(req_data.key_id);
         tgt_ff  <= ID_BITS'(req_data.target_id);
      end
      if (state_ff == S_RESOLVE) begin
         mapped_ff <= mapped_c;
         found_ff  <= ks_found;
         status_ff <= status_c;
         wkey_ff   <= wkey_c;
         wval_ff   <= wval_c;
         ra_ff     <= ra_c;
         rb_ff     <= rb_c;
         rv_ff     <= rv_c;
      end
      if (state_ff == S_UPDATE) begin
         rsp_ff.mapped_id <= 32'(mapped_ff);
         rsp_ff.found     <= found_ff;
         rsp_ff.status    <= (do_write_ff && !found_w && valid_vec[TABLE_DEPTH-1]) ?
                             STATUS_FULL : status_ff;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/ist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_cell
// One table entry: valid bit, key and value, with its own key compares and
// value rewrite. Entries fill in order, the valid bit handed down the row.
// ----------------------------------------------------------------------------
module ist_cell
   import ist_pkg::*;
#(
   parameter int ID_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [ID_BITS-1:0]  cmp_key,
   input  logic [ID_BITS-1:0]  cmp_tgt,
   input  logic [ID_BITS-1:0]  find_key,
   input  logic [ID_BITS-1:0]  write_value,
   input  logic [ID_BITS-1:0]  rw_a,
   input  logic [ID_BITS-1:0]  rw_b,
   input  logic [ID_BITS-1:0]  rw_v,
   input  logic                prev_valid,
   output logic                valid,
   output cell_hit_type        hit,
   output logic [ID_BITS-1:0]  khit_value,
   output logic [ID_BITS-1:0]  thit_value
);

   logic               valid_ff, valid_in;
   logic               khit_ff, thit_ff, whit_ff;
   logic [ID_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0] value_ff, value_in;
   logic               alloc_here, write_here, rewrite_here;
   logic [ID_BITS-1:0] value_put;

   always_comb begin
      alloc_here   = ctrl.write_new && !valid_ff && prev_valid;
      write_here   = (ctrl.write_hit && whit_ff) || alloc_here;
      value_put    = write_here ? write_value : value_ff;
      valid_in     = valid_ff || alloc_here;
      rewrite_here = ctrl.rewrite_en && valid_in &&
                     ((value_put == rw_a) || (ctrl.b_en && (value_put == rw_b)));
      value_in     = rewrite_here ? rw_v : value_put;
      key_in       = alloc_here ? find_key : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         khit_ff  <= 1'b0;
         thit_ff  <= 1'b0;
         whit_ff  <= 1'b0;
      end else begin
         if (ctrl.compare_en) begin
            khit_ff <= valid_ff && (key_ff == cmp_key);
            thit_ff <= valid_ff && ctrl.tgt_en && (key_ff == cmp_tgt);
         end
         if (ctrl.find_en) begin
            whit_ff <= valid_ff && (key_ff == find_key);
         end
         if (ctrl.update_en) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update_en) begin
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   assign valid      = valid_ff;
   assign hit.khit   = khit_ff;
   assign hit.thit   = thit_ff;
   assign hit.whit   = whit_ff;
   assign khit_value = khit_ff ? value_ff : '0;
   assign thit_value = thit_ff ? value_ff : '0;

endmodule

@@ test/ist_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Watches the request and response channels of the identity substitution
// table. It keeps its own copy of the table and updates it for the accepted
// unify transactions. It queues the expected response and compares each
// strobed response with the oldest entry, field by field.
// ----------------------------------------------------------------------------
module ist_checker
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   logic        tbl_valid [TABLE_DEPTH];
   logic [31:0] tbl_key   [TABLE_DEPTH];
   logic [31:0] tbl_value [TABLE_DEPTH];
   rsp_type     answer_q[$];

   initial begin
      mismatch_count = 0;
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_value[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t ns] mismatch: %s", $time, msg);
   endtask

   function automatic int slot_of(input logic [31:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_valid[i] && tbl_key[i] == id) return i;
      end
      return -1;
   endfunction

   // overwrite an existing entry or claim the lowest free one
   function automatic bit store_entry(input logic [31:0] id, input logic [31:0] val);
      int s;
      s = slot_of(id);
      if (s >= 0) begin
         tbl_value[s] = val;
         return 1'b1;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_key[i]   = id;
            tbl_value[i] = val;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void redirect_values(input logic [31:0] old_a, input logic [31:0] old_b,
                                           input logic [31:0] new_val);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_valid[i] && (tbl_value[i] == old_a || (old_b != 0 && tbl_value[i] == old_b)))
            tbl_value[i] = new_val;
      end
   endfunction

   function automatic rsp_type lookup_or_unify(input req_type r);
      int          ks;
      int          ts;
      logic [31:0] resolved;
      logic [31:0] existing;
      rsp_type     o;
      ks       = slot_of(r.key_id);
      o.found  = (ks >= 0);
      o.status = STATUS_DONE;
      if (r.mode == MODE_LOOKUP) begin
         o.mapped_id = (ks >= 0) ? tbl_value[ks] : r.key_id;
         return o;
      end
      ts          = (r.target_id != 0) ? slot_of(r.target_id) : -1;
      resolved    = (r.target_id == 0) ? '0 : ((ts >= 0) ? tbl_value[ts] : r.target_id);
      o.mapped_id = resolved;
      if (r.key_id == 0) begin
         o.status = STATUS_ZERO_KEY;
      end else if (r.key_id == r.target_id) begin
         o.status = STATUS_SKIPPED;
      end else if (ks < 0) begin
         if (!store_entry(r.key_id, resolved)) o.status = STATUS_FULL;
         redirect_values(r.key_id, '0, resolved);
      end else begin
         existing = tbl_value[ks];
         if (existing == 0) begin
            if (resolved != 0) begin
               if (!store_entry(resolved, '0)) o.status = STATUS_FULL;
               redirect_values(resolved, '0, '0);
            end else begin
               o.status = STATUS_SKIPPED;
            end
         end else if (resolved == 0) begin
            if (!store_entry(existing, '0)) o.status = STATUS_FULL;
            redirect_values(existing, r.key_id, '0);
         end else begin
            if (!store_entry(r.target_id, existing)) o.status = STATUS_FULL;
            redirect_values(resolved, '0, existing);
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.mapped_id !== want.mapped_id)
                  report_mismatch($sformatf("mapped_id %h, expected %h",
                                            rsp_data.mapped_id, want.mapped_id));
               if (rsp_data.found !== want.found)
                  report_mismatch($sformatf("found %b, expected %b",
                                            rsp_data.found, want.found));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
            end
         end
         if (start && !busy) answer_q.push_back(lookup_or_unify(req_data));
      end
      pending_count <= answer_q.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookup and unify transactions into the identity substitution table.
// A directed run walks zero keys, identical pairs, literalizing and the
// transitive rewrite cases; random phases then draw identities from pools of
// growing size so that hits are frequent early and the table fills later.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import ist_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 900;
   localparam int POOL_MAX       = 128;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_count;
   int      idle_cycles = 0;
   bit      no_gaps     = 1'b0;
   logic [31:0] id_pool [POOL_MAX];

   identity_substitution_table DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ist_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** identity_substitution_table: FAILED **");
         $finish;
      end
   end

   function automatic req_type mk(input logic m, input logic [31:0] k, input logic [31:0] t);
      req_type r;
      r.mode      = m;
      r.key_id    = k;
      r.target_id = t;
      return r;
   endfunction

   // offer one transaction after a random gap and hold it until taken
   task automatic send(input req_type r);
      int gap;
      if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic req_type random_item(input int pool_size);
      int      pick;
      req_type r;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // noise, mostly lookups of arbitrary identities
         r = mk(($urandom_range(0, 3) == 0) ? MODE_UNIFY : MODE_LOOKUP, $urandom, $urandom);
      end else if (pick < 15) begin
         r = mk(1'($urandom_range(0, 1)), '0, id_pool[$urandom_range(0, pool_size - 1)]);
      end else if (pick < 20) begin
         r = mk(MODE_UNIFY, id_pool[$urandom_range(0, pool_size - 1)], '0);
         r.target_id = r.key_id;
      end else begin
         r = mk(1'($urandom_range(0, 1)), id_pool[$urandom_range(0, pool_size - 1)],
                id_pool[$urandom_range(0, pool_size - 1)]);
         if ($urandom_range(0, 99) < 15) r.target_id = '0;
      end
      return r;
   endfunction

   initial begin
      logic [31:0] id_a;
      logic [31:0] id_b;
      logic [31:0] id_c;
      logic [31:0] id_d;
      logic [31:0] id_e;
      int          pool_size;
      id_a = 32'hFFFF_FFFF;
      id_b = 32'h8000_0001;
      id_c = 32'h0000_0001;
      id_d = 32'h7FFF_FFFE;
      id_e = 32'h1234_5678;
      foreach (id_pool[i]) begin
         id_pool[i] = $urandom;
         if (id_pool[i] == 0) id_pool[i] = 32'(i + 1);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send(mk(MODE_LOOKUP, '0, '0));
      send(mk(MODE_LOOKUP, id_a, id_b));
      send(mk(MODE_UNIFY, '0, id_b));
      send(mk(MODE_UNIFY, '0, '0));
      send(mk(MODE_UNIFY, id_a, id_a));
      send(mk(MODE_UNIFY, id_a, id_b));
      send(mk(MODE_LOOKUP, id_a, '0));
      send(mk(MODE_UNIFY, '0, id_a));
      send(mk(MODE_UNIFY, id_c, id_a));
      send(mk(MODE_UNIFY, id_a, id_d));
      send(mk(MODE_LOOKUP, id_d, '0));
      send(mk(MODE_UNIFY, id_a, '0));
      send(mk(MODE_LOOKUP, id_c, '0));
      send(mk(MODE_UNIFY, id_a, '0));
      send(mk(MODE_UNIFY, id_a, id_e));
      send(mk(MODE_LOOKUP, id_e, '0));
      send(mk(MODE_UNIFY, id_c, id_c));
      send(mk(MODE_UNIFY, id_b, id_d));
      send(mk(MODE_LOOKUP, id_b, '0));
      send(mk(MODE_LOOKUP, id_d, '0));
      send(mk(MODE_UNIFY, 32'h0000_0002, 32'hFFFF_FFFE));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) wait_all_answered();
         pool_size = (n < 300) ? 10 : ((n < 600) ? 40 : POOL_MAX);
         send(random_item(pool_size));
      end

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** identity_substitution_table: PASSED **");
      end else begin
         $display("** identity_substitution_table: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/ist_pkg.sv
src/ist_cell.sv
src/identity_substitution_table.sv
test/ist_checker.sv
test/testbench.sv
